// ===== sv/thph_pkg.sv =====
// Shared types, field widths and helpers for the threshold projection histogram.
package thph_pkg;

    localparam int PIX_W = 8;
    localparam int COL_W = 9;
    localparam int IDX_W = 9;
    localparam int CNT_W = 10;
    localparam int CMD_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam int DEF_IMAGE_WIDTH  = 512;
    localparam int DEF_IMAGE_HEIGHT = 512;

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd128;
    localparam logic [CNT_W-1:0] COUNT_MAX    = 10'd1023;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL    = 2'd0,
        CMD_END_ROW  = 2'd1,
        CMD_START    = 2'd2,
        CMD_READ_COL = 2'd3
    } cmd_t;

    typedef enum logic {
        KIND_ROW = 1'b0,
        KIND_COL = 1'b1
    } kind_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

// ===== sv/threshold_projection_histogram_core.sv =====
// Top level of the threshold projection histogram: row tallies and per-column count store.
//
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | s_tuser cmd, s_tdata pixel_value, read_column
//  m_      | out | m_tvalid / m_tready   | m_tuser result_kind, m_tdata index, count
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_data pixel_threshold
//
// One transfer per cycle unless stalled; results pass the update and output registers.
// The column store is read on accept and written back by the update stage, with bypass.
// After reset the store is swept to zero with s_tready low;
// cfg_ready stays high throughout.
// A result that cannot enter the output register holds the update stage and drops s_tready.
module threshold_projection_histogram_core #(
    parameter int IMAGE_WIDTH  = thph_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = thph_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] pixel_value, [16:8] read_column, [23:17] zero
    input  logic [thph_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [thph_pkg::CMD_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [8:0] result_index, [18:9] result_count, [23:19] zero
    output logic [thph_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] result_kind
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [thph_pkg::PIX_W-1:0]     cfg_data
);

    localparam int AW  = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
    localparam int CPW = $clog2(IMAGE_WIDTH + 1);
    localparam int RW  = $clog2(IMAGE_HEIGHT);
    localparam int XW  = ((AW > thph_pkg::COL_W) ? AW : thph_pkg::COL_W) + 1;
    localparam int RXW = (RW > thph_pkg::IDX_W) ? RW : thph_pkg::IDX_W;
    localparam int PXW = ((CPW > thph_pkg::CNT_W) ? CPW : thph_pkg::CNT_W) + 1;

    logic [thph_pkg::PIX_W-1:0] thresh_reg;

    logic [CPW-1:0]             col_pos_reg, col_pos_next;
    logic [thph_pkg::CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [RW-1:0]              row_num_reg, row_num_next;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_result_reg;
    logic                       s1_kind_reg;
    logic                       s1_write_reg;
    logic                       s1_clear_reg;
    logic                       s1_hit_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic [thph_pkg::IDX_W-1:0] s1_index_reg;
    logic [thph_pkg::CNT_W-1:0] s1_count_reg;

    logic                       m_valid_reg;
    logic                       m_kind_reg;
    logic [thph_pkg::IDX_W-1:0] m_index_reg;
    logic [thph_pkg::CNT_W-1:0] m_count_reg;

    thph_pkg::cmd_t             cmd;
    logic [thph_pkg::PIX_W-1:0] pix;
    logic [XW-1:0]              col_ext;
    logic [RXW-1:0]             row_ext;
    logic                       col_in_range;
    logic                       pos_in_range;
    logic                       pix_hit;
    logic                       in_fire;
    logic                       out_free;
    logic                       s1_fire;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [thph_pkg::CNT_W-1:0] rd_data;
    logic                       wr_en;
    logic [thph_pkg::CNT_W-1:0] wr_data;
    logic                       store_busy;

    assign cmd          = thph_pkg::cmd_t'(s_tuser);
    assign pix          = s_tdata[7:0];
    assign col_ext      = XW'(s_tdata[16:8]);
    assign row_ext      = RXW'(row_num_reg);
    assign col_in_range = col_ext < XW'(IMAGE_WIDTH);
    assign pos_in_range = col_pos_reg < CPW'(IMAGE_WIDTH);
    assign pix_hit      = pix > thresh_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_result_reg || out_free);
    assign s_tready = !store_busy && (!s1_valid_reg || s1_fire);
    assign in_fire  = s_tvalid && s_tready;

    assign rd_en   = in_fire && (((cmd == thph_pkg::CMD_PIXEL) && pos_in_range && pix_hit) ||
                                 ((cmd == thph_pkg::CMD_READ_COL) && col_in_range));
    assign rd_addr = (cmd == thph_pkg::CMD_READ_COL) ? col_ext[AW-1:0] : col_pos_reg[AW-1:0];
    assign wr_en   = s1_fire && s1_write_reg;
    assign wr_data = s1_clear_reg ? '0 : thph_pkg::sat_inc(rd_data);

    thph_col_store #(
        .DEPTH (IMAGE_WIDTH),
        .AW    (AW)
    ) u_col_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (store_busy)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= thph_pkg::THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thresh_reg <= cfg_data;
        end
    end

    always_comb begin
        col_pos_next = col_pos_reg;
        row_cnt_next = row_cnt_reg;
        row_num_next = row_num_reg;
        if (in_fire) begin
            case (cmd)
                thph_pkg::CMD_PIXEL: begin
                    if (pos_in_range) begin
                        col_pos_next = col_pos_reg + 1'b1;
                        if (pix_hit) begin
                            row_cnt_next = thph_pkg::sat_inc(row_cnt_reg);
                        end
                    end
                end
                thph_pkg::CMD_END_ROW: begin
                    col_pos_next = '0;
                    row_cnt_next = '0;
                    if (row_num_reg < RW'(IMAGE_HEIGHT - 1)) begin
                        row_num_next = row_num_reg + 1'b1;
                    end
                end
                thph_pkg::CMD_START: begin
                    col_pos_next = '0;
                    row_cnt_next = '0;
                    row_num_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg  <= '0;
            row_cnt_reg  <= '0;
            row_num_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            col_pos_reg  <= col_pos_next;
            row_cnt_reg  <= row_cnt_next;
            row_num_reg  <= row_num_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_fire && s1_result_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_result_reg <= (cmd == thph_pkg::CMD_END_ROW) || (cmd == thph_pkg::CMD_READ_COL);
            s1_kind_reg   <= (cmd == thph_pkg::CMD_READ_COL) ? thph_pkg::KIND_COL
                                                            : thph_pkg::KIND_ROW;
            s1_write_reg  <= rd_en;
            s1_clear_reg  <= (cmd == thph_pkg::CMD_READ_COL);
            s1_hit_reg    <= col_in_range;
            s1_addr_reg   <= rd_addr;
            s1_index_reg  <= (cmd == thph_pkg::CMD_READ_COL) ? s_tdata[16:8]
                                                            : row_ext[thph_pkg::IDX_W-1:0];
            s1_count_reg  <= row_cnt_reg;
        end
        if (s1_fire && s1_result_reg) begin
            m_kind_reg  <= s1_kind_reg;
            m_index_reg <= s1_index_reg;
            if (s1_kind_reg == thph_pkg::KIND_COL) begin
                m_count_reg <= s1_hit_reg ? rd_data : '0;
            end else begin
                m_count_reg <= s1_count_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_index_reg};

    a_no_accept_in_sweep : assert property (@(posedge aclk) disable iff (!aresetn)
        store_busy |-> !s_tready)
        else $error("input accepted during column store sweep");

    a_stalled_stage_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |-> !s_tready)
        else $error("input accepted while update stage is stalled");

    a_row_cnt_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        PXW'(row_cnt_reg) <= PXW'(col_pos_reg))
        else $error("row count exceeds column position");

    a_store_write_once : assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> !s1_valid_reg || !s1_write_reg || s1_fire || !$stable(s1_addr_reg)
                  || $past(in_fire) || !wr_en)
        else $error("column store written twice by one item");

endmodule

// ===== sv/thph_col_store.sv =====
// Column count memory: one write port, one registered read port with write bypass, clear sweep.
module thph_col_store #(
    parameter int DEPTH = thph_pkg::DEF_IMAGE_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [thph_pkg::CNT_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [thph_pkg::CNT_W-1:0] rd_data,
    output logic                       busy
);

    logic [thph_pkg::CNT_W-1:0] mem [DEPTH];
    logic [thph_pkg::CNT_W-1:0] rd_data_reg;
    logic                       clr_active_reg, clr_active_next;
    logic [AW-1:0]              clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule
